>>> hdl/clps_pkg.sv
package clps_pkg;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_CELL  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam int CMD_W    = 2;
   localparam int CELL_W   = 16;
   localparam int COST_W   = 8;
   localparam int RBIN_W   = 11;
   localparam int ORANGE_W = 17;
   localparam int CSR_AW   = 5;

   localparam logic [4:0] ITER_LAST   = 5'd31;
   localparam logic [2:0] REG_POSE_X  = 3'd0;
   localparam logic [2:0] REG_POSE_Y  = 3'd1;
   localparam logic [2:0] REG_HEADING = 3'd2;
   localparam logic [2:0] REG_ORG_X   = 3'd3;
   localparam logic [2:0] REG_ORG_Y   = 3'd4;
   localparam logic [2:0] REG_CELL_SZ = 3'd5;
   localparam logic [2:0] REG_THRESH  = 3'd6;
   localparam logic [2:0] REG_RMAX    = 3'd7;

   typedef struct packed {
      logic accept_cell;
      logic do_add;
      logic do_prep;
      logic do_sum;
      logic do_iter;
      logic do_ang;
      logic do_bin;
      logic mem_fill;
      logic rd_req;
      logic rd_bin;
      logic out_zero;
      logic out_read_oob;
      logic out_read;
      logic out_clear;
      logic out_cell;
   } dp_cmd_type;

   typedef struct packed {
      logic cell_hit;
      logic read_ok;
   } dp_stat_type;

   // arctangent of 2^-i in 1/65536 turn
   function automatic logic [13:0] atab(input logic [3:0] i);
      logic [13:0] v;
      case (i)
         4'd0:    v = 14'd8192;
         4'd1:    v = 14'd4836;
         4'd2:    v = 14'd2555;
         4'd3:    v = 14'd1297;
         4'd4:    v = 14'd651;
         4'd5:    v = 14'd326;
         4'd6:    v = 14'd163;
         4'd7:    v = 14'd81;
         4'd8:    v = 14'd41;
         4'd9:    v = 14'd20;
         4'd10:   v = 14'd10;
         4'd11:   v = 14'd5;
         4'd12:   v = 14'd3;
         4'd13:   v = 14'd1;
         4'd14:   v = 14'd1;
         default: v = 14'd0;
      endcase
      return v;
   endfunction

endpackage

>>> hdl/cell_list_polar_min_range_scan_top.sv
// The result strobe is registered. An unused command, a cell below threshold or an out-of-range
// read is answered from idle; a read passes its wait state; a clear sweeps every bin;
// an occupied cell runs add, prep, sum, a 32-step root loop shared with the 16-step angle
// rotation, angle, bin, read and update. Requests are taken only while busy is low, and
// results cannot stall. After reset the bin store is swept to the clear range with busy high;
// configuration writes are taken throughout.
module cell_list_polar_min_range_scan_top #(
   parameter int RAY_COUNT = 1080,
   parameter int RANGE_BITS = 17
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [15:0] req_cell_x,
   input  logic [15:0] req_cell_y,
   input  logic [7:0]  req_cell_cost,
   input  logic [10:0] req_read_bin,
   output logic        rsp_strobe,
   output logic [10:0] rsp_bin_number,
   output logic [16:0] rsp_bin_range_mm,
   output logic        rsp_bin_lowered,
   output logic        rsp_cell_used,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int IDX_W = $clog2(RAY_COUNT);
   localparam int CNT_W = (IDX_W > 5) ? IDX_W : 5;

   logic [31:0] pose_x_ff, pose_y_ff, origin_x_ff, origin_y_ff;
   logic [15:0] heading_ff, cell_size_ff;
   logic [7:0]  thresh_ff;
   logic [16:0] clear_mm_ff;
   logic        wr;
   logic [2:0]  ridx;

   clps_pkg::dp_cmd_type  dcmd;
   clps_pkg::dp_stat_type stat;
   logic [CNT_W-1:0]      cnt;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign ridx   = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         pose_x_ff    <= '0;
         pose_y_ff    <= '0;
         heading_ff   <= '0;
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         cell_size_ff <= 16'd200;
         thresh_ff    <= 8'd127;
         clear_mm_ff  <= 17'd70000;
      end else if (wr) begin
         case (ridx)
            clps_pkg::REG_POSE_X:  pose_x_ff    <= pwdata;
            clps_pkg::REG_POSE_Y:  pose_y_ff    <= pwdata;
            clps_pkg::REG_HEADING: heading_ff   <= pwdata[15:0];
            clps_pkg::REG_ORG_X:   origin_x_ff  <= pwdata;
            clps_pkg::REG_ORG_Y:   origin_y_ff  <= pwdata;
            clps_pkg::REG_CELL_SZ: cell_size_ff <= pwdata[15:0];
            clps_pkg::REG_THRESH:  thresh_ff    <= pwdata[7:0];
            clps_pkg::REG_RMAX:    clear_mm_ff  <= pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (ridx)
         clps_pkg::REG_POSE_X:  prdata = pose_x_ff;
         clps_pkg::REG_POSE_Y:  prdata = pose_y_ff;
         clps_pkg::REG_HEADING: prdata = {16'd0, heading_ff};
         clps_pkg::REG_ORG_X:   prdata = origin_x_ff;
         clps_pkg::REG_ORG_Y:   prdata = origin_y_ff;
         clps_pkg::REG_CELL_SZ: prdata = {16'd0, cell_size_ff};
         clps_pkg::REG_THRESH:  prdata = {24'd0, thresh_ff};
         clps_pkg::REG_RMAX:    prdata = {15'd0, clear_mm_ff};
         default:               prdata = '0;
      endcase
   end

   clps_ctrl #(
      .RAY_COUNT (RAY_COUNT),
      .CNT_W     (CNT_W)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .cmd   (req_cmd),
      .stat  (stat),
      .busy  (busy),
      .cnt   (cnt),
      .dcmd  (dcmd)
   );

   clps_dp #(
      .RAY_COUNT  (RAY_COUNT),
      .RANGE_BITS (RANGE_BITS),
      .CNT_W      (CNT_W)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .dcmd             (dcmd),
      .cnt              (cnt),
      .stat             (stat),
      .req_cell_x       (req_cell_x),
      .req_cell_y       (req_cell_y),
      .req_cell_cost    (req_cell_cost),
      .req_read_bin     (req_read_bin),
      .pose_x           (pose_x_ff),
      .pose_y           (pose_y_ff),
      .heading          (heading_ff),
      .origin_x         (origin_x_ff),
      .origin_y         (origin_y_ff),
      .cell_size        (cell_size_ff),
      .thresh           (thresh_ff),
      .clear_mm         (clear_mm_ff),
      .rsp_strobe       (rsp_strobe),
      .rsp_bin_number   (rsp_bin_number),
      .rsp_bin_range_mm (rsp_bin_range_mm),
      .rsp_bin_lowered  (rsp_bin_lowered),
      .rsp_cell_used    (rsp_cell_used)
   );

endmodule

>>> hdl/clps_ctrl.sv
module clps_ctrl #(
   parameter int RAY_COUNT = 1080,
   parameter int CNT_W = 11
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             cmd,
   input  clps_pkg::dp_stat_type  stat,
   output logic                   busy,
   output logic [CNT_W-1:0]       cnt,
   output clps_pkg::dp_cmd_type   dcmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CLR  = 4'd1;
   localparam logic [3:0] S_ADD  = 4'd2;
   localparam logic [3:0] S_PREP = 4'd3;
   localparam logic [3:0] S_SUM  = 4'd4;
   localparam logic [3:0] S_ITER = 4'd5;
   localparam logic [3:0] S_ANG  = 4'd6;
   localparam logic [3:0] S_BIN  = 4'd7;
   localparam logic [3:0] S_RD   = 4'd8;
   localparam logic [3:0] S_UPD  = 4'd9;
   localparam logic [3:0] S_RDW  = 4'd10;

   localparam logic [CNT_W-1:0] SWEEP_LAST = CNT_W'(RAY_COUNT - 1);

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             report_ff, report_in;
   logic             accept;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign cnt    = cnt_ff;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      report_in = report_ff;
      dcmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (cmd)
                  clps_pkg::CMD_CLEAR: begin
                     cnt_in    = '0;
                     report_in = 1'b1;
                     state_in  = S_CLR;
                  end
                  clps_pkg::CMD_CELL: begin
                     if (stat.cell_hit) begin
                        dcmd.accept_cell = 1'b1;
                        state_in         = S_ADD;
                     end else begin
                        dcmd.out_zero = 1'b1;
                     end
                  end
                  clps_pkg::CMD_READ: begin
                     if (stat.read_ok) begin
                        dcmd.rd_req = 1'b1;
                        state_in    = S_RDW;
                     end else begin
                        dcmd.out_read_oob = 1'b1;
                     end
                  end
                  default: dcmd.out_zero = 1'b1;
               endcase
            end
         end
         S_CLR: begin
            dcmd.mem_fill = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == SWEEP_LAST) begin
               dcmd.out_clear = report_ff;
               state_in       = S_IDLE;
            end
         end
         S_ADD: begin
            dcmd.do_add = 1'b1;
            state_in    = S_PREP;
         end
         S_PREP: begin
            dcmd.do_prep = 1'b1;
            state_in     = S_SUM;
         end
         S_SUM: begin
            dcmd.do_sum = 1'b1;
            cnt_in      = '0;
            state_in    = S_ITER;
         end
         S_ITER: begin
            dcmd.do_iter = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff[4:0] == clps_pkg::ITER_LAST) begin
               state_in = S_ANG;
            end
         end
         S_ANG: begin
            dcmd.do_ang = 1'b1;
            state_in    = S_BIN;
         end
         S_BIN: begin
            dcmd.do_bin = 1'b1;
            state_in    = S_RD;
         end
         S_RD: begin
            dcmd.rd_bin = 1'b1;
            state_in    = S_UPD;
         end
         S_UPD: begin
            dcmd.out_cell = 1'b1;
            state_in      = S_IDLE;
         end
         S_RDW: begin
            dcmd.out_read = 1'b1;
            state_in      = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLR;
         cnt_ff    <= '0;
         report_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         report_ff <= report_in;
      end
   end

   a_reset_sweeps: assert property (@(posedge clock) !reset && $past(reset) |-> busy)
      else $error("no clearing pass after reset");

   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      accept && cmd == clps_pkg::CMD_CLEAR |=> busy && cnt_ff == '0)
      else $error("clear request did not start the sweep");

   a_iter_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ITER && cnt_ff[4:0] == clps_pkg::ITER_LAST |=> state_ff == S_ANG)
      else $error("iteration count overran");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      $countones({dcmd.out_zero, dcmd.out_read_oob, dcmd.out_read,
                  dcmd.out_clear, dcmd.out_cell}) <= 1)
      else $error("two results loaded at once");

endmodule

>>> hdl/clps_dp.sv
module clps_dp #(
   parameter int RAY_COUNT = 1080,
   parameter int RANGE_BITS = 17,
   parameter int CNT_W = 11
) (
   input  logic                   clock,
   input  logic                   reset,
   input  clps_pkg::dp_cmd_type   dcmd,
   input  logic [CNT_W-1:0]       cnt,
   output clps_pkg::dp_stat_type  stat,
   input  logic [15:0]            req_cell_x,
   input  logic [15:0]            req_cell_y,
   input  logic [7:0]             req_cell_cost,
   input  logic [10:0]            req_read_bin,
   input  logic [31:0]            pose_x,
   input  logic [31:0]            pose_y,
   input  logic [15:0]            heading,
   input  logic [31:0]            origin_x,
   input  logic [31:0]            origin_y,
   input  logic [15:0]            cell_size,
   input  logic [7:0]             thresh,
   input  logic [16:0]            clear_mm,
   output logic                   rsp_strobe,
   output logic [10:0]            rsp_bin_number,
   output logic [16:0]            rsp_bin_range_mm,
   output logic                   rsp_bin_lowered,
   output logic                   rsp_cell_used
);

   localparam int IDX_W = $clog2(RAY_COUNT);
   localparam logic [63:0] RMAX64 = (64'd1 << RANGE_BITS) - 64'd1;
   localparam logic [12:0] NR13 = 13'(RAY_COUNT);
   localparam logic [12:0] BIN_LAST = 13'(RAY_COUNT - 1);

   logic [RANGE_BITS-1:0] ray_mem [RAY_COUNT];
   logic [RANGE_BITS-1:0] rdata_ff;
   logic [IDX_W-1:0]      raddr, waddr;
   logic [RANGE_BITS-1:0] wdata;
   logic                  wen;
   logic [RANGE_BITS-1:0] fill_val;

   logic [31:0]        prodx_ff, prody_ff;
   logic signed [32:0] offx_ff, offy_ff;
   logic signed [33:0] dx_ff, dy_ff;
   logic               negx_ff, negy_ff, far_ff, zero_ff;
   logic [61:0]        sqx_ff, sqy_ff;
   logic signed [33:0] cx_ff, cy_ff;
   logic signed [17:0] z_ff;
   logic [63:0]        n_ff, res_ff;
   logic [15:0]        rel_ff;
   logic [RANGE_BITS-1:0] dist_ff;
   logic [IDX_W-1:0]   bin_ff;
   logic [10:0]        rbin_ff;

   logic [33:0] ax, ay, axy, nx, ny;
   logic [2:0]  nsh;
   logic [4:0]  k;
   logic [5:0]  sh;
   logic [63:0] bitv, trial;
   logic signed [33:0] xs, ys;
   logic signed [17:0] at;
   logic [14:0] zc;
   logic [15:0] ang;
   logic [15:0] hrel;
   logic [28:0] bprod;
   logic [12:0] braw;
   logic        lower;
   logic [12:0] rb_ext;

   assign fill_val = RANGE_BITS'({15'd0, clear_mm});
   assign rb_ext   = {2'b00, req_read_bin};

   assign stat.cell_hit = (req_cell_cost > thresh);
   assign stat.read_ok  = (rb_ext < NR13);

   // bin store: one write and one registered read per cycle
   always_comb begin
      raddr = bin_ff;
      if (dcmd.rd_req) begin
         raddr = rb_ext[IDX_W-1:0];
      end
      lower = ({32'd0, dist_ff} < {32'd0, rdata_ff});
      wen   = dcmd.mem_fill || (dcmd.out_cell && lower);
      waddr = dcmd.mem_fill ? cnt[IDX_W-1:0] : bin_ff;
      wdata = dcmd.mem_fill ? fill_val : dist_ff;
   end

   always_ff @(posedge clock) begin
      if (wen) begin
         ray_mem[waddr] <= wdata;
      end
      rdata_ff <= ray_mem[raddr];
   end

   always_comb begin
      ax  = dx_ff[33] ? 34'(-dx_ff) : 34'(dx_ff);
      ay  = dy_ff[33] ? 34'(-dy_ff) : 34'(dy_ff);
      axy = ax | ay;
      if (axy[33])      nsh = 3'd4;
      else if (axy[32]) nsh = 3'd3;
      else if (axy[31]) nsh = 3'd2;
      else if (axy[30]) nsh = 3'd1;
      else              nsh = 3'd0;
      nx = ax >> nsh;
      ny = ay >> nsh;

      k     = cnt[4:0];
      sh    = 6'd62 - {k, 1'b0};
      bitv  = 64'd1 << sh;
      trial = res_ff + bitv;
      xs    = cx_ff >>> k[3:0];
      ys    = cy_ff >>> k[3:0];
      at    = 18'({4'd0, clps_pkg::atab(k[3:0])});

      if (z_ff[17])                      zc = 15'd0;
      else if (z_ff > 18'sd16384)        zc = 15'd16384;
      else                               zc = z_ff[14:0];
      if (zero_ff)                       ang = 16'd0;
      else if (!negx_ff && !negy_ff)     ang = {1'b0, zc};
      else if (negx_ff && !negy_ff)      ang = 16'd32768 - {1'b0, zc};
      else if (negx_ff)                  ang = 16'd32768 + {1'b0, zc};
      else                               ang = 16'd0 - {1'b0, zc};

      hrel  = rel_ff + 16'h8000;
      bprod = {13'd0, hrel} * {16'd0, NR13};
      braw  = bprod[28:16];
   end

   always_ff @(posedge clock) begin
      if (dcmd.accept_cell) begin
         prodx_ff <= {16'd0, req_cell_x} * {16'd0, cell_size};
         prody_ff <= {16'd0, req_cell_y} * {16'd0, cell_size};
         offx_ff  <= $signed({origin_x[31], origin_x}) - $signed({pose_x[31], pose_x});
         offy_ff  <= $signed({origin_y[31], origin_y}) - $signed({pose_y[31], pose_y});
      end
      if (dcmd.do_add) begin
         dx_ff <= $signed({2'b00, prodx_ff}) + $signed({offx_ff[32], offx_ff});
         dy_ff <= $signed({2'b00, prody_ff}) + $signed({offy_ff[32], offy_ff});
      end
      if (dcmd.do_prep) begin
         negx_ff <= dx_ff[33];
         negy_ff <= dy_ff[33];
         far_ff  <= (|ax[33:31]) || (|ay[33:31]);
         zero_ff <= (ax == '0) && (ay == '0);
         sqx_ff  <= ax[30:0] * ax[30:0];
         sqy_ff  <= ay[30:0] * ay[30:0];
         cx_ff   <= $signed(nx);
         cy_ff   <= $signed(ny);
      end
      if (dcmd.do_sum) begin
         n_ff   <= {2'b00, sqx_ff} + {2'b00, sqy_ff};
         res_ff <= '0;
         z_ff   <= '0;
      end
      if (dcmd.do_iter) begin
         // one root bit per cycle
         if (n_ff >= trial) begin
            n_ff   <= n_ff - trial;
            res_ff <= (res_ff >> 1) + bitv;
         end else begin
            res_ff <= res_ff >> 1;
         end
         // one rotation per cycle for the first sixteen
         if (!k[4]) begin
            if (cy_ff > 34'sd0) begin
               cx_ff <= cx_ff + ys;
               cy_ff <= cy_ff - xs;
               z_ff  <= z_ff + at;
            end else begin
               cx_ff <= cx_ff - ys;
               cy_ff <= cy_ff + xs;
               z_ff  <= z_ff - at;
            end
         end
      end
      if (dcmd.do_ang) begin
         rel_ff <= ang - heading;
         if (far_ff || res_ff > RMAX64) begin
            dist_ff <= RMAX64[RANGE_BITS-1:0];
         end else begin
            dist_ff <= res_ff[RANGE_BITS-1:0];
         end
      end
      if (dcmd.do_bin) begin
         bin_ff <= (braw > BIN_LAST) ? BIN_LAST[IDX_W-1:0] : braw[IDX_W-1:0];
      end
      if (dcmd.rd_req) begin
         rbin_ff <= req_read_bin;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= dcmd.out_zero || dcmd.out_read_oob || dcmd.out_read
                       || dcmd.out_clear || dcmd.out_cell;
      end
      if (dcmd.out_zero) begin
         rsp_bin_number   <= '0;
         rsp_bin_range_mm <= '0;
         rsp_bin_lowered  <= 1'b0;
         rsp_cell_used    <= 1'b0;
      end else if (dcmd.out_read_oob) begin
         rsp_bin_number   <= req_read_bin;
         rsp_bin_range_mm <= '0;
         rsp_bin_lowered  <= 1'b0;
         rsp_cell_used    <= 1'b0;
      end else if (dcmd.out_read) begin
         rsp_bin_number   <= rbin_ff;
         rsp_bin_range_mm <= 17'({32'd0, rdata_ff});
         rsp_bin_lowered  <= 1'b0;
         rsp_cell_used    <= 1'b0;
      end else if (dcmd.out_clear) begin
         rsp_bin_number   <= '0;
         rsp_bin_range_mm <= 17'({32'd0, fill_val});
         rsp_bin_lowered  <= 1'b0;
         rsp_cell_used    <= 1'b0;
      end else if (dcmd.out_cell) begin
         rsp_bin_number   <= 11'({13'd0, bin_ff});
         rsp_bin_range_mm <= lower ? 17'({32'd0, dist_ff}) : 17'({32'd0, rdata_ff});
         rsp_bin_lowered  <= lower;
         rsp_cell_used    <= 1'b1;
      end
   end

endmodule
